[rtl/hnp_pkg.sv]
// Shared types and constants of the hashed node pool.
package hnp_pkg;

   // Request codes on req_type.
   localparam logic [1:0] REQ_GET   = 2'd0;
   localparam logic [1:0] REQ_FIND  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // Result codes on rsp_status.
   localparam logic [2:0] ST_FOUND    = 3'd0;
   localparam logic [2:0] ST_INSERTED = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_ABSENT   = 3'd3;
   localparam logic [2:0] ST_CLEARED  = 3'd4;

   // Steps of the key mixing sequence.
   localparam logic [1:0] HASH_STEP_A = 2'd0;
   localparam logic [1:0] HASH_STEP_B = 2'd1;
   localparam logic [1:0] HASH_STEP_C = 2'd2;

   localparam int KEY_W    = 64;
   localparam int LIMIT_W  = 11;
   localparam int STATUS_W = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   // Register index taken from paddr[2].
   localparam logic REG_NODE_LIMIT = 1'b0;

   typedef struct packed {
      logic                load;        // capture the key of a new item
      logic                hash_en;     // run one mixing step
      logic [1:0]          hash_sel;    // which mixing step
      logic                head_read;   // read the bucket head
      logic                load_head;   // start the walk at the bucket head
      logic                follow_link; // advance to the next node of the chain
      logic                finish;      // commit the outcome and load the result
      logic [STATUS_W-1:0] outcome;
   } hnp_cmd_type;

   typedef struct packed {
      logic walk_end;   // chain exhausted at the current node
      logic key_match;  // current node holds the key
      logic pool_full;  // allocation count has reached the cap
   } hnp_status_type;

endpackage

[rtl/hnp_ctrl.sv]
// Controller state machine of the hashed node pool.
module hnp_ctrl
   import hnp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [1:0]     req_type,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  hnp_status_type status,
   output hnp_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_HASH   = 3'd1;
   localparam logic [2:0] S_HEAD   = 3'd2;
   localparam logic [2:0] S_LOAD   = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_CMP    = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          type_ff, type_in;
   logic [1:0]          step_ff, step_in;
   logic [STATUS_W-1:0] outcome_ff, outcome_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                can_finish;

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign can_finish = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      type_in      = type_ff;
      step_in      = step_ff;
      outcome_in   = outcome_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.hash_sel = step_ff;
      cmd.outcome  = outcome_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               type_in  = req_type;
               step_in  = HASH_STEP_A;
               case (req_type)
                  REQ_GET, REQ_FIND: state_in = S_HASH;
                  REQ_CLEAR: begin
                     outcome_in = ST_CLEARED;
                     state_in   = S_FINISH;
                  end
                  default: begin
                     outcome_in = ST_ABSENT;
                     state_in   = S_FINISH;
                  end
               endcase
            end
         end
         S_HASH: begin
            cmd.hash_en = 1'b1;
            step_in     = step_ff + 2'd1;
            if (step_ff == HASH_STEP_C) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            cmd.head_read = 1'b1;
            state_in      = S_LOAD;
         end
         S_LOAD: begin
            cmd.load_head = 1'b1;
            state_in      = S_READ;
         end
         S_READ: begin
            if (status.walk_end) begin
               if (type_ff == REQ_FIND) begin
                  outcome_in = ST_ABSENT;
               end else if (status.pool_full) begin
                  outcome_in = ST_FULL;
               end else begin
                  outcome_in = ST_INSERTED;
               end
               state_in = S_FINISH;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (status.key_match) begin
               outcome_in = ST_FOUND;
               state_in   = S_FINISH;
            end else begin
               cmd.follow_link = 1'b1;
               state_in        = S_READ;
            end
         end
         S_FINISH: begin
            if (can_finish) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff    <= type_in;
      step_ff    <= step_in;
      outcome_ff <= outcome_in;
   end

endmodule

[rtl/hnp_datapath.sv]
// Datapath of the hashed node pool: key mixing, node memories and result register.
module hnp_datapath
   import hnp_pkg::*;
#(
   parameter int POOL_DEPTH   = 1024,
   parameter int BUCKET_COUNT = 256,
   parameter int SLOT_W       = $clog2(POOL_DEPTH),
   parameter int COUNT_W      = $clog2(POOL_DEPTH + 1),
   parameter int BUCKET_W     = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1
)(
   input  logic                clock,
   input  logic                reset,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [LIMIT_W-1:0]  node_limit,
   input  hnp_cmd_type         cmd,
   output hnp_status_type      status,
   output logic [SLOT_W-1:0]   rsp_slot_index,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_used_count
);

   localparam int CAP_W = (COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W;
   localparam logic [CAP_W-1:0] DEPTH_CAP   = CAP_W'(POOL_DEPTH);
   localparam logic [31:0]      BUCKET_MASK = 32'(BUCKET_COUNT - 1);

   // Node memories and bucket heads; a link carries its valid flag on top.
   logic [KEY_W-1:0]  key_mem  [POOL_DEPTH];
   logic [SLOT_W:0]   link_mem [POOL_DEPTH];
   logic [SLOT_W-1:0] head_mem [BUCKET_COUNT];

   logic [BUCKET_COUNT-1:0] head_valid_ff, head_valid_in;
   logic [COUNT_W-1:0]      alloc_ff, alloc_in;
   logic [KEY_W-1:0]        key_ff;
   logic [KEY_W-1:0]        hash_ff, hash_in;
   logic [SLOT_W-1:0]       head_q_ff;
   logic                    head_have_ff;
   logic [SLOT_W-1:0]       cur_ff, cur_in;
   logic                    have_ff, have_in;
   logic [KEY_W-1:0]        key_q_ff;
   logic [SLOT_W:0]         link_q_ff;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [STATUS_W-1:0]     status_ff;
   logic [COUNT_W-1:0]      used_ff, used_in;

   logic [KEY_W-1:0]  mix_sum;
   logic [BUCKET_W-1:0] bucket;
   logic [SLOT_W-1:0] alloc_slot;
   logic [CAP_W-1:0]  limit_ext, cap;
   logic              do_insert;

   // One add and one xor-shift per mixing step.
   always_comb begin
      case (cmd.hash_sel)
         HASH_STEP_A: begin
            mix_sum = hash_ff + ~(hash_ff << 31);
            hash_in = mix_sum ^ (mix_sum >> 20);
         end
         HASH_STEP_B: begin
            mix_sum = hash_ff + (hash_ff << 6);
            hash_in = mix_sum ^ (mix_sum >> 12);
         end
         HASH_STEP_C: begin
            mix_sum = hash_ff + ~(hash_ff << 22);
            hash_in = mix_sum ^ (mix_sum >> 32);
         end
         default: begin
            mix_sum = hash_ff;
            hash_in = hash_ff;
         end
      endcase
   end

   assign bucket     = BUCKET_W'(hash_ff[31:0] & BUCKET_MASK);
   assign alloc_slot = alloc_ff[SLOT_W-1:0];
   assign limit_ext  = CAP_W'(node_limit);
   assign cap        = (limit_ext < DEPTH_CAP) ? limit_ext : DEPTH_CAP;
   assign do_insert  = cmd.finish && (cmd.outcome == ST_INSERTED);

   assign status.walk_end  = !have_ff || (COUNT_W'(cur_ff) >= alloc_ff);
   assign status.key_match = (key_q_ff == key_ff);
   assign status.pool_full = (CAP_W'(alloc_ff) >= cap);

   always_comb begin
      cur_in  = cur_ff;
      have_in = have_ff;
      if (cmd.load_head) begin
         cur_in  = head_q_ff;
         have_in = head_valid_ff[bucket];
      end else if (cmd.follow_link) begin
         cur_in  = link_q_ff[SLOT_W-1:0];
         have_in = link_q_ff[SLOT_W];
      end
   end

   always_comb begin
      alloc_in      = alloc_ff;
      head_valid_in = head_valid_ff;
      slot_in       = slot_ff;
      used_in       = used_ff;
      if (cmd.finish) begin
         slot_in = '0;
         used_in = alloc_ff;
         case (cmd.outcome)
            ST_FOUND: slot_in = cur_ff;
            ST_INSERTED: begin
               slot_in               = alloc_slot;
               alloc_in              = alloc_ff + COUNT_W'(1);
               used_in               = alloc_in;
               head_valid_in[bucket] = 1'b1;
            end
            ST_CLEARED: begin
               alloc_in      = '0;
               used_in       = '0;
               head_valid_in = '0;
            end
            default: slot_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff      <= '0;
         head_valid_ff <= '0;
      end else begin
         alloc_ff      <= alloc_in;
         head_valid_ff <= head_valid_in;
      end
      if (cmd.load) begin
         key_ff  <= req_key;
         hash_ff <= req_key;
      end else if (cmd.hash_en) begin
         hash_ff <= hash_in;
      end
      if (cmd.load_head) begin
         head_have_ff <= head_valid_ff[bucket];
      end
      cur_ff  <= cur_in;
      have_ff <= have_in;
      if (cmd.finish) begin
         status_ff <= cmd.outcome;
      end
      slot_ff <= slot_in;
      used_ff <= used_in;
   end

   // Node memories: one registered read at the current node, one write at insert.
   always_ff @(posedge clock) begin
      key_q_ff  <= key_mem[cur_ff];
      link_q_ff <= link_mem[cur_ff];
      if (do_insert) begin
         key_mem[alloc_slot]  <= key_ff;
         link_mem[alloc_slot] <= {head_have_ff, head_q_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.head_read) begin
         head_q_ff <= head_mem[bucket];
      end
      if (do_insert) begin
         head_mem[bucket] <= alloc_slot;
      end
   end

   assign rsp_slot_index = slot_ff;
   assign rsp_status     = status_ff;
   assign rsp_used_count = used_ff;

endmodule

[rtl/hashed_node_pool_top.sv]
// Top level of the hashed node pool: configuration register, controller and datapath.
//
// The block keeps a pool of node slots addressed by a 64-bit key. Each item on
// the req_ channel carries a request code and a key; each item yields exactly
// one result item on the rsp_ channel with the slot index, a status code and
// the number of slots allocated after the request.
// An item is taken when req_valid is high and req_stall is low; results leave
// when rsp_valid is high and rsp_stall is low. One item is worked on at a time.
// A get-or-insert or find request mixes the key, reads the bucket head and then
// walks the chain; a hit ends the walk at the matching node. Each node costs
// one registered read of the key and link memories and one compare. The key
// mixing runs through the steps A, B and C, one 64-bit add each. A clear or an
// unused request code goes straight to the finish state.
// A finished result waits in an output register, so a new item is taken while
// the receiver stalls; that item then holds in its last cycle until the
// register is free.
// Reset clears the allocation count, every bucket's valid flag and the node limit
// (to 1024) at once; there is no clearing pass. The user writes the node limit over
// the APB-style port at byte address 0 while idle; the block does not enforce it.
module hashed_node_pool_top
   import hnp_pkg::*;
#(
   parameter int POOL_DEPTH   = 1024,
   parameter int BUCKET_COUNT = 256
)(
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_type,
   input  logic [KEY_W-1:0]                   req_key,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [$clog2(POOL_DEPTH)-1:0]      rsp_slot_index,
   output logic [STATUS_W-1:0]                rsp_status,
   output logic [$clog2(POOL_DEPTH + 1)-1:0]  rsp_used_count,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [CSR_ADDR_W-1:0]              paddr,
   input  logic [CSR_DATA_W-1:0]              pwdata,
   output logic [CSR_DATA_W-1:0]              prdata,
   output logic                               pready
);

   localparam int SLOT_W  = $clog2(POOL_DEPTH);
   localparam int COUNT_W = $clog2(POOL_DEPTH + 1);

   logic [LIMIT_W-1:0] node_limit_ff, node_limit_in;
   logic               csr_write;
   hnp_cmd_type        cmd;
   hnp_status_type     status;

   // The register index sits in paddr[2]; the low byte-address bits are ignored.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      node_limit_in = node_limit_ff;
      if (csr_write && (paddr[2] == REG_NODE_LIMIT)) begin
         node_limit_in = pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_limit_ff <= LIMIT_RESET;
      end else begin
         node_limit_ff <= node_limit_in;
      end
   end

   // Reads of addresses beyond the single register return zero.
   assign prdata = (paddr[2] == REG_NODE_LIMIT) ?
                   CSR_DATA_W'(node_limit_ff) : '0;

   hnp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hnp_datapath #(
      .POOL_DEPTH   (POOL_DEPTH),
      .BUCKET_COUNT (BUCKET_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_key        (req_key),
      .node_limit     (node_limit_ff),
      .cmd            (cmd),
      .status         (status),
      .rsp_slot_index (rsp_slot_index),
      .rsp_status     (rsp_status),
      .rsp_used_count (rsp_used_count)
   );

   // The allocation count can never pass the pool depth.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_used_count <= COUNT_W'(POOL_DEPTH)))
      else $error("used count beyond pool depth");

   // A freshly inserted node is always the last slot allocated.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_INSERTED)) |->
      (rsp_slot_index == SLOT_W'(rsp_used_count - COUNT_W'(1))))
      else $error("inserted slot does not match allocation count");

   // A clear leaves an empty pool behind it.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_CLEARED)) |->
      ((rsp_used_count == '0) && (rsp_slot_index == '0)))
      else $error("clear result not empty");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the hashed node pool: random and directed lookups against a predictor.
module tb;
   import hnp_pkg::*;

   // The block is built with its default sizes, so the predictor uses the same.
   localparam int POOL_SLOTS  = 1024;
   localparam int BUCKETS     = 256;

   // Request code that the block must treat as a no-op returning "absent".
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // The node limit is register 0, so it lives at byte address 0.
   localparam logic [CSR_ADDR_W-1:0] NODE_LIMIT_ADDR = {REG_NODE_LIMIT, 2'b00};

   // Cycles with no handshake of any kind before the run is declared hung.
   // The slowest item walks a full chain over 1024 nodes.
   localparam int QUIET_LIMIT = 20000;

   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 100;
   localparam int RECENT_KEYS   = 48;

   // One result item as the block should present it.
   typedef struct {
      logic [9:0]  slot;
      logic [2:0]  status;
      logic [10:0] used;
   } pool_answer_type;

   // Shadow copy of the pool, plus the queue of answers still owed by the block.
   class node_pool_scoreboard;
      bit [63:0]       slot_key  [POOL_SLOTS];
      bit [10:0]       next_link [POOL_SLOTS];
      bit              next_ok   [POOL_SLOTS];
      bit [10:0]       head      [BUCKETS];
      bit              head_ok   [BUCKETS];
      bit [10:0]       used;
      bit [10:0]       limit;
      pool_answer_type answers_due[$];
      int              errors;

      function new();
         foreach (head_ok[i]) head_ok[i] = 1'b0;
         used   = '0;
         limit  = LIMIT_RESET;
         errors = 0;
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         errors++;
      endtask

      // Fixed shift-add-xor mix of the key; the low byte picks the bucket.
      function bit [7:0] bucket_of(bit [63:0] k);
         bit [63:0] a;
         a = k;
         a = a + ~(a << 31);
         a = a ^ (a >> 20);
         a = a + (a << 6);
         a = a ^ (a >> 12);
         a = a + ~(a << 22);
         a = a ^ (a >> 32);
         return a[7:0];
      endfunction

      // Walks one bucket chain; the walk gives up on a stale link or after a
      // full pool's worth of steps.
      function bit find_slot(bit [7:0] b, bit [63:0] k, output bit [10:0] s);
         bit          have;
         bit [10:0]   idx;
         int unsigned steps;
         have  = head_ok[b];
         idx   = head[b];
         steps = 0;
         s     = '0;
         while (have && steps < POOL_SLOTS) begin
            if (idx >= used || int'(idx) >= POOL_SLOTS) return 1'b0;
            if (slot_key[idx] == k) begin
               s = idx;
               return 1'b1;
            end
            have = next_ok[idx];
            idx  = next_link[idx];
            steps++;
         end
         return 1'b0;
      endfunction

      function pool_answer_type predict_answer(logic [1:0] kind, logic [63:0] k);
         pool_answer_type a;
         bit [10:0]       s;
         bit [7:0]        b;
         bit [10:0]       cap;
         a.slot   = '0;
         a.status = ST_ABSENT;
         if (kind == REQ_CLEAR) begin
            foreach (head_ok[i]) head_ok[i] = 1'b0;
            used     = '0;
            a.status = ST_CLEARED;
         end else if (kind == REQ_GET || kind == REQ_FIND) begin
            b = bucket_of(k);
            if (find_slot(b, k, s)) begin
               a.status = ST_FOUND;
               a.slot   = s[9:0];
            end else if (kind == REQ_GET) begin
               cap = (int'(limit) < POOL_SLOTS) ? limit : 11'(POOL_SLOTS);
               if (used >= cap) begin
                  a.status = ST_FULL;
               end else begin
                  s            = used;
                  used         = used + 11'd1;
                  slot_key[s]  = k;
                  next_link[s] = head[b];
                  next_ok[s]   = head_ok[b];
                  head[b]      = s;
                  head_ok[b]   = 1'b1;
                  a.status     = ST_INSERTED;
                  a.slot       = s[9:0];
               end
            end
         end
         a.used = used;
         return a;
      endfunction

      function void note_request(logic [1:0] kind, logic [63:0] k);
         answers_due.push_back(predict_answer(kind, k));
      endfunction

      function int pending();
         return answers_due.size();
      endfunction

      task check_answer(logic [9:0] slot, logic [2:0] status, logic [10:0] used_now);
         pool_answer_type want;
         if (answers_due.size() == 0) begin
            report($sformatf("result with nothing outstanding (slot %0d status %0d)",
                             slot, status));
         end else begin
            want = answers_due.pop_front();
            if (status !== want.status)
               report($sformatf("status %0d, expected %0d", status, want.status));
            if (slot !== want.slot)
               report($sformatf("slot_index %0d, expected %0d", slot, want.slot));
            if (used_now !== want.used)
               report($sformatf("used_count %0d, expected %0d", used_now, want.used));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_type;
   logic [63:0] req_key;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [9:0]  rsp_slot_index;
   logic [2:0]  rsp_status;
   logic [10:0] rsp_used_count;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic        pready;

   node_pool_scoreboard sb = new();

   // When set, the sender or the receiver runs without any gaps or stalls.
   bit tx_burst = 1'b0;
   bit rx_burst = 1'b0;
   int rx_wait  = 0;
   int quiet_cycles = 0;

   // Keys that have recently been sent, reused to produce hits.
   logic [63:0] recent_keys[$];

   hashed_node_pool_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slot_index (rsp_slot_index),
      .rsp_status     (rsp_status),
      .rsp_used_count (rsp_used_count),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Results are taken at the rising edge. After each one the receiver draws
   // how long it will stall before the next.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_answer(rsp_slot_index, rsp_status, rsp_used_count);
         rx_wait = rx_burst ? 0 : $urandom_range(0, 10);
      end
   end

   // The stall line changes only at the falling edge, once per cycle.
   always @(negedge clock) begin
      if (rx_wait > 0) begin
         rsp_stall <= 1'b1;
         rx_wait = rx_wait - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: any handshake on either channel or the register port counts as
   // progress; a long silence means the block has hung.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Sends one item after a random gap and returns at the edge that took it.
   // The valid line is only lowered when a gap is wanted, so back-to-back
   // items keep it high without a glitch.
   task automatic send_item(input logic [1:0] kind, input logic [63:0] k);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= kind;
      req_key   <= k;
      do @(posedge clock); while (req_stall);
      sb.note_request(kind, k);
   endtask

   // Drops valid and waits until every owed result has come back, so that the
   // block is idle and a register write is safe.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One APB access: setup cycle, then access cycle until pready.
   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= NODE_LIMIT_ADDR;
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Writes the node limit, mirrors it in the predictor and reads it back.
   task automatic set_node_limit(input logic [10:0] value);
      logic [CSR_DATA_W-1:0] rd;
      wait_idle();
      csr_access(1'b1, CSR_DATA_W'(value), rd);
      sb.limit = value;
      csr_access(1'b0, '0, rd);
      if (rd !== CSR_DATA_W'(value))
         sb.report($sformatf("node_limit reads %0d, expected %0d", rd, value));
   endtask

   function automatic logic [63:0] fresh_key();
      return {$urandom, $urandom};
   endfunction

   // Random key that lands in a chosen bucket, used to build long chains.
   function automatic logic [63:0] key_in_bucket(input logic [7:0] target);
      logic [63:0] k;
      k = fresh_key();
      while (sb.bucket_of(k) != target) k = fresh_key();
      return k;
   endfunction

   function automatic logic [63:0] reuse_key();
      if (recent_keys.size() == 0) return fresh_key();
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
   endfunction

   function automatic void remember_key(input logic [63:0] k);
      recent_keys.push_back(k);
      if (recent_keys.size() > RECENT_KEYS) void'(recent_keys.pop_front());
   endfunction

   // Draws one random item. Most are lookups of keys seen before, so that
   // hits and deep chains are common; a share of new keys falls into one
   // busy bucket to grow a long chain; clears and the unused code are rare.
   task automatic send_random_item(input logic [7:0] busy_bucket);
      int          r;
      logic [63:0] k;
      logic [1:0]  kind;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         kind = REQ_GET;
         k    = reuse_key();
      end else if (r < 68) begin
         kind = REQ_GET;
         k    = ($urandom_range(0, 3) == 0) ? key_in_bucket(busy_bucket) : fresh_key();
      end else if (r < 90) begin
         kind = REQ_FIND;
         k    = ($urandom_range(0, 1) == 0) ? reuse_key() : fresh_key();
      end else if (r < 93) begin
         kind = REQ_CLEAR;
         k    = fresh_key();
      end else begin
         kind = REQ_UNUSED;
         k    = fresh_key();
      end
      if (kind == REQ_GET || kind == REQ_FIND) remember_key(k);
      send_item(kind, k);
   endtask

   logic [63:0]  ones_key;
   logic [63:0]  chain_keys[5];
   logic [63:0]  key_a;
   logic [63:0]  key_b;
   logic [10:0]  phase_limits[RANDOM_PHASES];

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_type  = REQ_GET;
      req_key   = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      ones_key  = '1;
      key_a     = 64'h5555_5555_5555_5555;
      key_b     = 64'haaaa_aaaa_aaaa_aaaa;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset limit: empty pool, insert, hit, the key
      // extremes, and the unused request code.
      send_item(REQ_FIND, '0);
      send_item(REQ_GET, '0);
      send_item(REQ_GET, '0);
      send_item(REQ_GET, ones_key);
      send_item(REQ_FIND, ones_key);
      send_item(REQ_UNUSED, ones_key);

      // Several keys sharing the bucket of key zero, so that lookups have to
      // walk the chain; the last one is never inserted and walks it to the end.
      foreach (chain_keys[i]) chain_keys[i] = key_in_bucket(sb.bucket_of('0));
      for (int i = 0; i < 4; i++) send_item(REQ_GET, chain_keys[i]);
      send_item(REQ_FIND, chain_keys[0]);
      send_item(REQ_FIND, '0);
      send_item(REQ_FIND, chain_keys[4]);

      // A clear empties every bucket and starts allocation from slot zero.
      send_item(REQ_CLEAR, ones_key);
      send_item(REQ_FIND, '0);
      send_item(REQ_GET, ones_key);

      // A limit of zero: every miss of a get reports full, hits still work.
      set_node_limit(11'd0);
      send_item(REQ_GET, key_a);
      send_item(REQ_FIND, key_a);
      send_item(REQ_GET, ones_key);

      // A limit of one: the second distinct key does not fit.
      set_node_limit(11'd1);
      send_item(REQ_CLEAR, '0);
      send_item(REQ_GET, key_a);
      send_item(REQ_GET, key_b);
      send_item(REQ_GET, key_a);

      // The widest limit is taken as the pool depth.
      set_node_limit(11'd2047);
      send_item(REQ_GET, key_b);

      // Random part: each phase runs under its own limit, the extremes among
      // them. Some phases drop all gaps on one or both sides.
      phase_limits = '{11'd1024, 11'd5, 11'd0, 11'd2047, 11'd1, 11'd60, 11'd1024, 11'd300};
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         logic [7:0] busy_bucket;
         busy_bucket = 8'($urandom);
         set_node_limit(phase_limits[p]);
         tx_burst = (p == 2 || p == 5);
         rx_burst = (p == 3 || p == 5);
         if ($urandom_range(0, 1) == 0) send_item(REQ_CLEAR, fresh_key());
         for (int i = 0; i < PHASE_ITEMS; i++) send_random_item(busy_bucket);
      end

      // Drain: every owed result must come back before the watchdog fires.
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (30) @(posedge clock);

      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
